// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width of the window length register
    localparam int CFG_W = 7;

    // Window length after reset
    localparam logic [CFG_W-1:0] LEN_RESET = 7'd3;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } swm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // take the offered sample
        logic issue_read;  // read one older ring entry
        logic load_out;    // move the maximum into the output register
    } swm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic produce;     // offered sample completes a window
        logic single;      // window length is one, nothing to scan
        logic scan_last;   // this read is the final one of the scan
        logic slot_free;   // output register can take a result
    } swm_status_t;

endpackage

// ===== rtl/swm_sample_if.sv =====
// ----------------------------------------------------------------------------
// swm_sample_if
// Input channel: one signed sample and its end-of-sequence flag per transfer.
// ----------------------------------------------------------------------------
interface swm_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== rtl/swm_result_if.sv =====
// ----------------------------------------------------------------------------
// swm_result_if
// Output channel: one window maximum and its end-of-sequence flag per transfer.
// ----------------------------------------------------------------------------
interface swm_result_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           last_result;

    modport source (output valid, output window_max, output last_result, input ready);
    modport sink   (input valid, input window_max, input last_result, output ready);
endinterface

// ===== rtl/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: accepts a sample, runs the ring scan, hands off the result.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);
    import swm_pkg::*;

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.issue_read = 1'b0;
        cmd.load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.produce)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.single)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue_read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read data is folded in by the datapath this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.slot_free)
        else $error("result loaded while output register busy");

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> $past(state_reg == ST_SCAN))
        else $error("drain entered without a scan");

endmodule

// ===== rtl/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// Ring store, fill tracking, running maximum and output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  logic                              last_sample,
    input  swm_pkg::swm_cmd_t                 cmd,
    output swm_pkg::swm_status_t              status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    window_max,
    output logic                              last_result
);
    import swm_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_MAX);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(WINDOW_MAX);

    logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];

    logic [CFG_W-1:0]               len_cfg_reg;
    logic [IDX_W-1:0]               wr_idx_reg;
    logic [CNT_W-1:0]               fill_reg;
    logic [IDX_W-1:0]               rd_ptr_reg;
    logic [LEN_W-1:0]               scan_cnt_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                           rd_pend_reg;
    logic signed [SAMPLE_WIDTH-1:0] best_reg;
    logic                           last_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_max_reg;
    logic                           out_last_reg;

    logic [LEN_W-1:0] cfg_ext;
    logic [LEN_W-1:0] eff_len;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] wr_idx_inc;
    logic [IDX_W-1:0] wr_idx_dec;
    logic [IDX_W-1:0] rd_ptr_dec;

    // zero length acts as one, oversize saturates
    always_comb
    begin
        cfg_ext = LEN_W'(len_cfg_reg);
        if (cfg_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (cfg_ext > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = cfg_ext;
        end
    end

    assign fill_next  = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + 1'b1;
    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign wr_idx_dec = (wr_idx_reg == '0) ? LAST_IDX : wr_idx_reg - 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - 1'b1;

    assign status.produce   = LEN_W'(fill_next) >= eff_len;
    assign status.single    = eff_len == LEN_W'(1);
    assign status.scan_last = scan_cnt_reg == LEN_W'(1);
    assign status.slot_free = !out_valid_reg || out_ready;

    // ring store: one write port on accept, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ring_mem[wr_idx_reg] <= sample;
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= LEN_RESET;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_cfg_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                wr_idx_reg <= last_sample ? '0 : wr_idx_inc;
                fill_reg   <= last_sample ? '0 : fill_next;
            end
            rd_pend_reg <= cmd.issue_read;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan pointer, running maximum, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_ptr_reg   <= wr_idx_dec;
            scan_cnt_reg <= eff_len - 1'b1;
            best_reg     <= sample;
            last_reg     <= last_sample;
        end
        else
        begin
            if (cmd.issue_read)
            begin
                rd_ptr_reg   <= rd_ptr_dec;
                scan_cnt_reg <= scan_cnt_reg - 1'b1;
            end
            if (rd_pend_reg && (rd_data_reg > best_reg))
            begin
                best_reg <= rd_data_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_max_reg  <= best_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign window_max  = out_max_reg;
    assign last_result = out_last_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond ring depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> (scan_cnt_reg != '0))
        else $error("ring read issued past the window");

endmodule

// ===== rtl/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of the most recent window_length signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples  : sink channel, one signed sample plus last_sample per transfer.
//   results  : source channel, window_max plus last_result per transfer.
//   cfg_we / cfg_wdata : write of window_length (0 acts as 1, values above
//              WINDOW_MAX saturate). Write only while the block is idle.
//   Once the current sequence holds window_length samples, each sample gives
//   one result over it and the older samples; earlier samples give none.
//   A transfer with last_sample set ends the sequence and empties the window.
// Sequence, with L the effective window length:
//   A sample that gives no result is taken and the block stays idle.
//   Otherwise the ring is walked one older entry per cycle through its single
//   read port: accept, then L-1 reads and a drain (both skipped for L = 1),
//   then the hand-off. The result is valid on the cycle after the hand-off.
// Reset: window length returns to 3, window empty, output register empty.
//   The ring memory itself is not cleared; the fill count guards it.
// Stall: a result waits in the output register while the next sample is
//   taken; the hand-off of that next result waits until the register frees.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
    swm_sample_if.sink                samples,
    swm_result_if.source              results
);
    import swm_pkg::*;

    swm_cmd_t    cmd;
    swm_status_t status;

    // controller: decides when to take a sample, scan, and hand off
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: ring, counters, running max, output register
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .sample      (samples.sample),
        .last_sample (samples.last_sample),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .window_max  (results.window_max),
        .last_result (results.last_result)
    );

endmodule
